### sv/scaled_span_texel_blitter_macros.svh
// assertion macros for the span blitter checker
`ifndef SCALED_SPAN_TEXEL_BLITTER_MACROS_SVH
`define SCALED_SPAN_TEXEL_BLITTER_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SSTB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SSTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/sstb_pkg.sv
// ----------------------------------------------------------------------------
// sstb_pkg
// types and constants shared by the span blitter modules
// ----------------------------------------------------------------------------
package sstb_pkg;

    localparam logic [1:0] KIND_TEXEL = 2'd0;
    localparam logic [1:0] KIND_TABLE = 2'd1;
    localparam logic [1:0] KIND_SETUP = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    localparam logic [2:0] MODE_OPAQUE    = 3'd0;
    localparam logic [2:0] MODE_KEY       = 3'd1;
    localparam logic [2:0] MODE_TABLE     = 3'd2;
    localparam logic [2:0] MODE_TABLE_KEY = 3'd3;
    localparam logic [2:0] MODE_SOLID     = 3'd4;

    localparam logic REG_DRAW_MODE   = 1'b0;
    localparam logic REG_SOLID_COLOR = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [11:0]        store_index;
        logic [7:0]         store_value;
        logic signed [31:0] left_edge_x;
        logic signed [31:0] right_edge_x;
        logic signed [31:0] left_edge_u;
        logic signed [31:0] right_edge_u;
        logic signed [31:0] start_v;
        logic signed [31:0] step_v;
        logic [10:0]        first_row;
        logic [10:0]        row_count;
    } item_t;

    typedef struct packed {
        logic [10:0] pixel_x;
        logic [10:0] pixel_y;
        logic [7:0]  pixel_color;
        logic        write_enable;
        logic        row_done;
        logic        span_done;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_PRE_MUL,
        ST_PRE_ADD,
        ST_TEX_RD,
        ST_TAB_RD,
        ST_EMIT
    } state_t;

    // divider request/status between sequencer and divider
    typedef struct packed {
        logic        start;
    } div_ctl_t;

    typedef struct packed {
        logic        busy;
        logic        done;
    } div_sts_t;

endpackage

### sv/sstb_ram.sv
// ----------------------------------------------------------------------------
// sstb_ram
// generic ram with one write port and one read port, registered read
// ----------------------------------------------------------------------------
module sstb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/sstb_div.sv
// ----------------------------------------------------------------------------
// sstb_div
// radix-2 signed divider, 49-bit dividend by 33-bit divisor, saturated to 32
// ----------------------------------------------------------------------------
module sstb_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sstb_pkg::div_ctl_t   ctl,
    input  logic signed [48:0]   dividend,
    input  logic signed [32:0]   divisor,
    output sstb_pkg::div_sts_t   sts,
    output logic [31:0]          quotient
);
    import sstb_pkg::*;

    logic [48:0] rem_reg, rem_next;
    logic [48:0] quo_reg, quo_next;
    logic [32:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [49:0] trial;
    logic [48:0] shifted_rem;
    logic [48:0] shifted_quo;
    logic signed [49:0] sq;

    always_comb
    begin
        shifted_rem = {rem_reg[47:0], quo_reg[48]};
        shifted_quo = {quo_reg[47:0], 1'b0};
        trial = {1'b0, shifted_rem} - {17'd0, dvs_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            rem_next = '0;
            quo_next = dividend[48] ? 49'(-dividend) : 49'(dividend);
            dvs_next = divisor[32] ? 33'(-divisor) : 33'(divisor);
            neg_next = dividend[48] ^ divisor[32];
            cnt_next = 6'd49;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[49])
            begin
                rem_next = trial[48:0];
                quo_next = {shifted_quo[48:1], 1'b1};
            end
            else
            begin
                rem_next = shifted_rem;
                quo_next = shifted_quo;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // sign and saturate the magnitude quotient
    always_comb
    begin
        sq = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        if (sq > 50'sd2147483647)
        begin
            quotient = 32'h7FFF_FFFF;
        end
        else if (sq < -50'sd2147483648)
        begin
            quotient = 32'h8000_0000;
        end
        else
        begin
            quotient = sq[31:0];
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
endmodule

### sv/scaled_span_texel_blitter.sv
// timing: store writes and rejected spans never raise busy; a span setup holds
// busy through divider load, 49 divider steps, done, one multiply and one add;
// a pixel tick holds busy through texture read, table read and emit states
// throughput: one transaction at a time, busy covers the whole item
// the result strobe lasts one cycle and cannot be stalled
// reset (rst_n, async low) clears control state and ends any span; the
// texture and color table stay unknown until written
// ----------------------------------------------------------------------------
// scaled_span_texel_blitter
// texture-mapped span pixel generator with colorkey, color table and solid mode
// ----------------------------------------------------------------------------
module scaled_span_texel_blitter #(
    parameter int TEX_WIDTH  = 64,
    parameter int TEX_HEIGHT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sstb_pkg::item_t   item,
    output logic              strobe,
    output sstb_pkg::result_t result,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data
);
    import sstb_pkg::*;

    localparam int CW = $clog2(TEX_WIDTH);
    localparam int RW = $clog2(TEX_HEIGHT);
    localparam int TA = CW + RW;
    localparam int TEX_SIZE = TEX_WIDTH * TEX_HEIGHT;

    state_t state_reg, state_next;

    logic [2:0]  mode_reg;
    logic [7:0]  solid_reg;
    logic [31:0] u_row_reg, u_acc_reg, u_step_reg, v_acc_reg, v_step_reg;
    // span end can reach 32768, so the columns carry a 17-bit signed range
    logic [16:0] x_begin_reg, x_end_reg, x_pos_reg;
    logic [10:0] y_pos_reg, rows_reg;
    logic        active_reg;

    // setup scratch
    logic signed [32:0] xs_reg;
    logic signed [31:0] lx_reg, lu_reg;
    logic signed [32:0] frac_reg;
    logic signed [63:0] prod_reg;

    logic [7:0]  texel;
    logic [7:0]  clut;
    logic        strobe_reg;
    result_t     result_reg;

    div_ctl_t    dctl;
    div_sts_t    dsts;
    logic [31:0] quot;

    // ceil of 16.16 values
    logic signed [32:0] xs_c, xe_c;
    assign xs_c = (33'(item.left_edge_x) + 33'sd65535) >>> 16;
    assign xe_c = (33'(item.right_edge_x) + 33'sd65535) >>> 16;

    logic accept;
    assign accept = start && !busy;

    logic signed [48:0] dvd;
    logic signed [32:0] dvs;
    assign dvd = (49'(item.right_edge_u) - 49'(item.left_edge_u)) <<< 16;
    assign dvs = 33'(item.right_edge_x) - 33'(item.left_edge_x);
    assign dctl.start = accept && item.kind == KIND_SETUP && xe_c > xs_c;

    sstb_div u_div (
        .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(dvd),
        .divisor(dvs), .sts(dsts), .quotient(quot)
    );

    // texture address: floor(u), floor(v) wrapped
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    assign col = CW'(u_acc_reg[31:16]);
    assign row = RW'(v_acc_reg[31:16]);

    logic [TA-1:0] tex_raddr;
    assign tex_raddr = {row, col};

    logic tex_we, tab_we;
    assign tex_we = accept && item.kind == KIND_TEXEL && 32'(item.store_index) < TEX_SIZE;
    assign tab_we = accept && item.kind == KIND_TABLE && item.store_index < 12'd256;

    sstb_ram #(.WIDTH(8), .DEPTH(TEX_SIZE)) u_tex (
        .clk(clk), .we(tex_we), .waddr(TA'(item.store_index)),
        .wdata(item.store_value), .raddr(tex_raddr), .rdata(texel)
    );

    sstb_ram #(.WIDTH(8), .DEPTH(256)) u_clut (
        .clk(clk), .we(tab_we), .waddr(item.store_index[7:0]),
        .wdata(item.store_value), .raddr(texel), .rdata(clut)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (dctl.start)
                begin
                    state_next = ST_DIV;
                end
                else if (accept && item.kind == KIND_TICK && active_reg)
                begin
                    state_next = ST_TEX_RD;
                end
            end
            ST_DIV:     if (dsts.done) state_next = ST_PRE_MUL;
            ST_PRE_MUL: state_next = ST_PRE_ADD;
            ST_PRE_ADD: state_next = ST_IDLE;
            ST_TEX_RD:  state_next = ST_TAB_RD;
            ST_TAB_RD:  state_next = ST_EMIT;
            ST_EMIT:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy = (state_reg != ST_IDLE);
    end

    // pixel color
    logic       we_c;
    logic [7:0] color_c;
    logic       rdone_c, sdone_c;
    always_comb
    begin
        we_c = 1'b0;
        color_c = '0;
        case (mode_reg)
            MODE_OPAQUE:    begin we_c = 1'b1; color_c = texel; end
            MODE_KEY:       begin we_c = texel != 0; color_c = texel; end
            MODE_TABLE:     begin we_c = 1'b1; color_c = clut; end
            MODE_TABLE_KEY: begin we_c = texel != 0; color_c = we_c ? clut : 8'd0; end
            MODE_SOLID:     begin we_c = texel != 0; color_c = we_c ? solid_reg : 8'd0; end
            default:        begin we_c = 1'b0; color_c = '0; end
        endcase
        rdone_c = $signed(x_pos_reg) + 17'sd1 >= $signed(x_end_reg);
        sdone_c = rdone_c && rows_reg <= 11'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg <= '0;
            solid_reg <= '0;
            u_row_reg <= '0; u_acc_reg <= '0; u_step_reg <= '0;
            v_acc_reg <= '0; v_step_reg <= '0;
            x_begin_reg <= '0; x_end_reg <= '0; x_pos_reg <= '0;
            y_pos_reg <= '0; rows_reg <= '0;
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            strobe_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DRAW_MODE:   mode_reg <= cfg_data[2:0];
                    REG_SOLID_COLOR: solid_reg <= cfg_data;
                    default:         solid_reg <= solid_reg;
                endcase
            end
            if (accept && item.kind == KIND_SETUP)
            begin
                if (xe_c > xs_c)
                begin
                    v_acc_reg <= item.start_v;
                    v_step_reg <= item.step_v;
                    x_begin_reg <= xs_c[16:0];
                    x_end_reg <= xe_c[16:0];
                    x_pos_reg <= xs_c[16:0];
                    y_pos_reg <= item.first_row;
                    rows_reg <= item.row_count == 0 ? 11'd1 : item.row_count;
                end
                active_reg <= 1'b0;
            end
            if (state_reg == ST_DIV && dsts.done)
            begin
                u_step_reg <= quot;
            end
            if (state_reg == ST_PRE_ADD)
            begin
                // floor of the pre-step product
                u_row_reg <= lu_reg + prod_reg[47:16];
                u_acc_reg <= lu_reg + prod_reg[47:16];
                active_reg <= 1'b1;
            end
            if (state_reg == ST_EMIT)
            begin
                strobe_reg <= 1'b1;
                if (rdone_c)
                begin
                    v_acc_reg <= v_acc_reg + v_step_reg;
                    y_pos_reg <= y_pos_reg + 11'd1;
                    rows_reg <= rows_reg - 11'd1;
                    x_pos_reg <= x_begin_reg;
                    u_acc_reg <= u_row_reg;
                    if (sdone_c)
                    begin
                        active_reg <= 1'b0;
                    end
                end
                else
                begin
                    x_pos_reg <= x_pos_reg + 17'd1;
                    u_acc_reg <= u_acc_reg + u_step_reg;
                end
            end
        end
    end

    // setup scratch and result payload
    always_ff @(posedge clk)
    begin
        if (accept && item.kind == KIND_SETUP)
        begin
            xs_reg <= xs_c;
            lx_reg <= item.left_edge_x;
            lu_reg <= item.left_edge_u;
        end
        if (state_reg == ST_DIV)
        begin
            frac_reg <= 33'((xs_reg <<< 16) - 49'(lx_reg));
        end
        if (state_reg == ST_PRE_MUL)
        begin
            // fractional distance fits in 17 bits
            prod_reg <= $signed(u_step_reg) * $signed(frac_reg[17:0]);
        end
        if (state_reg == ST_EMIT)
        begin
            result_reg.pixel_x <= x_pos_reg[10:0];
            result_reg.pixel_y <= y_pos_reg;
            result_reg.pixel_color <= color_c;
            result_reg.write_enable <= we_c;
            result_reg.row_done <= rdone_c;
            result_reg.span_done <= sdone_c;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;
endmodule

### sv/sstb_checker.sv
// ----------------------------------------------------------------------------
// sstb_checker
// port-level checks on the span blitter
// ----------------------------------------------------------------------------
`include "scaled_span_texel_blitter_macros.svh"

module sstb_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              strobe,
    input sstb_pkg::result_t result
);
    import sstb_pkg::*;

    `SSTB_ASSERT_NEXT(a_strobe_single, clk, rst_n, strobe, !strobe)
    `SSTB_ASSERT_IMPL(a_span_has_row, clk, rst_n, strobe && result.span_done, result.row_done)
    `SSTB_ASSERT_IMPL(a_skip_black, clk, rst_n, strobe && !result.write_enable, result.pixel_color == 8'd0)
    `SSTB_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, !strobe)
endmodule

bind scaled_span_texel_blitter sstb_checker u_sstb_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .strobe(strobe), .result(result)
);
